>>> src/slrg_pkg.sv
// Package for the shuffled Lehmer random generator.
// Holds generator constants, parameter defaults and request codes.
// No dependencies.
package slrg_pkg;

  // minimal-standard Lehmer generator
  localparam int unsigned LCG_MUL = 16807;
  localparam int unsigned LCG_MOD = 32'd2147483647;
  localparam int unsigned WARMUP  = 8;

  // parameter defaults
  localparam int unsigned TABLE_DEPTH_DEF    = 32;
  localparam int unsigned WORD_WIDTH_MAX_DEF = 64;

  // field widths
  localparam int unsigned GEN_W   = 31;
  localparam int unsigned FUNC_W  = 2;
  localparam int unsigned WIDTH_W = 7;
  localparam int unsigned VALUE_W = 64;

  // request codes
  typedef enum logic [FUNC_W-1:0] {
    FUNC_UNIFORM = 2'd0,
    FUNC_BIT     = 2'd1,
    FUNC_WORD    = 2'd2,
    FUNC_NONE    = 2'd3
  } func_t;

endpackage

>>> src/shuffled_lehmer_random_generator.sv
// A uniform draw from an initialised generator runs MUL_G, FOLD, MUL_L, ACCESS and TAKE;
// the first draw after reset or a seed write first runs INIT_MUL and INIT_FOLD for
// TABLE_DEPTH+8 generator steps. A fair bit takes a pair of draws, repeated on rejected
// pairs; a word takes width fair bits. Function code 3 and width 0 answer 0 in the next
// cycle. All draws share one multiplier: one transaction at a time, busy high meanwhile.
// Synchronous active-low reset: seed 1, not initialised; the table needs no clearing pass.
// Top level of the shuffled Lehmer random generator (single module).
// Depends on slrg_pkg.
module shuffled_lehmer_random_generator #(
  parameter int unsigned TABLE_DEPTH    = slrg_pkg::TABLE_DEPTH_DEF,
  parameter int unsigned WORD_WIDTH_MAX = slrg_pkg::WORD_WIDTH_MAX_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic [slrg_pkg::FUNC_W-1:0]       in_func,
  input  logic [slrg_pkg::WIDTH_W-1:0]      in_width,
  output logic                              out_strobe,
  output logic [slrg_pkg::VALUE_W-1:0]      out_value,
  input  logic                              cfg_wr_en,
  input  logic [slrg_pkg::GEN_W-1:0]        cfg_wr_data
);

  localparam int unsigned GW = slrg_pkg::GEN_W;
  localparam int unsigned AW = $clog2(TABLE_DEPTH);
  localparam int unsigned KW = $clog2(TABLE_DEPTH + slrg_pkg::WARMUP);
  localparam int unsigned CW = $clog2(WORD_WIDTH_MAX + 1);
  localparam int unsigned QW = AW + 1;

  // slot = last / SLOT_DIV as an exact multiply by a rounded-up reciprocal
  localparam longint unsigned SLOT_DIV =
    64'd1 + (64'(slrg_pkg::LCG_MOD) - 64'd1) / 64'(TABLE_DEPTH);
  localparam int unsigned DIV_LOG     = $clog2(SLOT_DIV);
  localparam int unsigned RECIP_SHIFT = GW + DIV_LOG;
  localparam longint unsigned RECIP_MUL =
    ((64'd1 << RECIP_SHIFT) + SLOT_DIV - 64'd1) / SLOT_DIV;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INIT_MUL,
    ST_INIT_FOLD,
    ST_MUL_G,
    ST_FOLD,
    ST_MUL_L,
    ST_ACCESS,
    ST_TAKE
  } state_t;

  state_t                     state_r;
  logic [GW-1:0]              seed_r;
  logic [GW-1:0]              gen_r;
  logic [GW-1:0]              last_r;
  logic [62:0]                prod_r;
  logic [KW-1:0]              k_r;
  logic                       is_uniform_r;
  logic                       phase_r;
  logic                       first_bit_r;
  logic [CW-1:0]              cnt_r;
  logic [CW-1:0]              target_r;
  logic [WORD_WIDTH_MAX-1:0]  word_r;
  logic [GW-1:0]              rd_r;
  logic                       out_strobe_r;
  logic [slrg_pkg::VALUE_W-1:0] out_value_r;

  logic [GW-1:0]              table_mem [TABLE_DEPTH];

  // shared multiplier operands
  logic                       mul_sel_last;
  logic [GW-1:0]              mul_a;
  logic [31:0]                mul_b;
  logic [32:0]                fold_sum;
  logic [GW-1:0]              fold_val;
  logic [QW-1:0]              slot_q;
  logic [AW-1:0]              slot;
  logic [GW-1:0]              seed_fix;
  logic [slrg_pkg::WIDTH_W-1:0] width_sat;
  logic                       draw_bit;
  logic [CW-1:0]              cnt_inc;
  logic                       mem_we;
  logic [AW-1:0]              mem_addr;
  logic [GW-1:0]              mem_wdata;

  assign mul_sel_last = (state_r == ST_MUL_L);
  assign mul_a        = mul_sel_last ? last_r : gen_r;
  assign mul_b        = mul_sel_last ? RECIP_MUL[31:0] : slrg_pkg::LCG_MUL;

  // mod 2^31-1 reduction of the product: fold high bits onto low bits
  assign fold_sum = 33'(prod_r[62:31]) + 33'(prod_r[30:0]);
  assign fold_val = (fold_sum >= 33'(slrg_pkg::LCG_MOD)) ?
                    GW'(fold_sum - 33'(slrg_pkg::LCG_MOD)) : GW'(fold_sum);

  // table slot from the reciprocal product, clamped to the top slot
  assign slot_q = QW'(prod_r >> RECIP_SHIFT);
  assign slot   = (slot_q >= QW'(TABLE_DEPTH)) ? AW'(TABLE_DEPTH - 1) : AW'(slot_q);

  // seed reduced mod 2^31-1, zero taken as one
  assign seed_fix = (seed_r == '0 || seed_r == GW'(slrg_pkg::LCG_MOD)) ? GW'(1) : seed_r;

  assign width_sat = (in_width > slrg_pkg::WIDTH_W'(WORD_WIDTH_MAX)) ?
                     slrg_pkg::WIDTH_W'(WORD_WIDTH_MAX) : in_width;

  // draw >= 2^30
  assign draw_bit = rd_r[GW-1];
  assign cnt_inc  = cnt_r + CW'(1);

  // table write port: init fill or shuffle replacement
  always_comb begin
    mem_we    = 1'b0;
    mem_addr  = slot;
    mem_wdata = gen_r;
    case (state_r)
      ST_INIT_FOLD: begin
        mem_we    = (k_r < KW'(TABLE_DEPTH));
        mem_addr  = AW'(k_r);
        mem_wdata = fold_val;
      end
      ST_ACCESS: begin
        mem_we = 1'b1;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  // shuffle table, read data registered
  always_ff @(posedge clk) begin
    if (state_r == ST_ACCESS) begin
      rd_r <= table_mem[slot];
    end
    if (mem_we) begin
      table_mem[mem_addr] <= mem_wdata;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      seed_r       <= GW'(1);
      gen_r        <= '0;
      last_r       <= '0;
      out_strobe_r <= 1'b0;
      phase_r      <= 1'b0;
      cnt_r        <= '0;
    end else begin
      out_strobe_r <= 1'b0;
      if (cfg_wr_en) begin
        seed_r <= cfg_wr_data;
        last_r <= '0;
      end
      case (state_r)
        ST_IDLE: begin
          if (start) begin
            is_uniform_r <= (in_func == slrg_pkg::FUNC_UNIFORM);
            target_r     <= (in_func == slrg_pkg::FUNC_WORD) ? CW'(width_sat) : CW'(1);
            word_r       <= '0;
            cnt_r        <= '0;
            phase_r      <= 1'b0;
            if (in_func == slrg_pkg::FUNC_NONE ||
                (in_func == slrg_pkg::FUNC_WORD && in_width == '0)) begin
              // nothing to draw
              out_strobe_r <= 1'b1;
              out_value_r  <= '0;
            end else if (last_r == '0) begin
              gen_r   <= seed_fix;
              k_r     <= KW'(TABLE_DEPTH + slrg_pkg::WARMUP - 1);
              state_r <= ST_INIT_MUL;
            end else begin
              state_r <= ST_MUL_G;
            end
          end
        end
        ST_INIT_MUL: begin
          prod_r  <= 63'(mul_a) * 63'(mul_b);
          state_r <= ST_INIT_FOLD;
        end
        ST_INIT_FOLD: begin
          gen_r <= fold_val;
          if (k_r == '0) begin
            // slot 0 seeds the previous output
            last_r  <= fold_val;
            state_r <= ST_MUL_G;
          end else begin
            k_r     <= k_r - KW'(1);
            state_r <= ST_INIT_MUL;
          end
        end
        ST_MUL_G: begin
          prod_r  <= 63'(mul_a) * 63'(mul_b);
          state_r <= ST_FOLD;
        end
        ST_FOLD: begin
          gen_r   <= fold_val;
          state_r <= ST_MUL_L;
        end
        ST_MUL_L: begin
          prod_r  <= 63'(mul_a) * 63'(mul_b);
          state_r <= ST_ACCESS;
        end
        ST_ACCESS: begin
          state_r <= ST_TAKE;
        end
        ST_TAKE: begin
          last_r <= rd_r;
          if (is_uniform_r) begin
            out_strobe_r <= 1'b1;
            out_value_r  <= slrg_pkg::VALUE_W'(rd_r);
            state_r      <= ST_IDLE;
          end else if (!phase_r) begin
            // first draw of a von Neumann pair
            first_bit_r <= draw_bit;
            phase_r     <= 1'b1;
            state_r     <= ST_MUL_G;
          end else begin
            phase_r <= 1'b0;
            state_r <= ST_MUL_G;
            if (first_bit_r != draw_bit) begin
              word_r <= {word_r[WORD_WIDTH_MAX-2:0], first_bit_r};
              cnt_r  <= cnt_inc;
              if (cnt_inc == target_r) begin
                out_strobe_r <= 1'b1;
                out_value_r  <= slrg_pkg::VALUE_W'({word_r[WORD_WIDTH_MAX-2:0],
                                                    first_bit_r});
                state_r      <= ST_IDLE;
              end
            end
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign busy       = (state_r != ST_IDLE);
  assign out_strobe = out_strobe_r;
  assign out_value  = out_value_r;

endmodule
